// ----- sv/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: operation and character
// codes, register indexes, field widths and reset defaults.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default geometry limits (top-level parameter defaults)
    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_TAB_STOP    = 4;

    // Register reset values
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Port field widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int TCOL_W     = 7;
    localparam int TROW_W     = 5;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ROWS_CFG_W = 6;

    localparam logic [ATTR_W-1:0] DEF_TEXT_ATTR  = 8'h0F;
    localparam logic [ATTR_W-1:0] DEF_BLANK_ATTR = 8'h07;

    // Cell value after power-up: char 0, attribute 7
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0700;

    // Operations
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR  = 2'd3;

endpackage

// ----- sv/tcw_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tcw_cfg_regs
// Configuration registers. Geometry is stored clamped, together with the
// cell count in use and the scroll copy length, all updated at the write.
// ----------------------------------------------------------------------------
module tcw_cfg_regs
    import tcw_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS,
    localparam int CNW        = $clog2(MAX_COLUMNS + 1),
    localparam int RNW        = $clog2(MAX_ROWS + 1),
    localparam int TW         = $clog2(CELL_COUNT + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [CNW-1:0]        cols,
    output logic [RNW-1:0]        rows,
    output logic [TW-1:0]         total,
    output logic [TW-1:0]         copy_lim,
    output logic [ATTR_W-1:0]     text_attr,
    output logic [ATTR_W-1:0]     blank_attr
);

    localparam int RST_COLS = (DEF_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : DEF_COLUMNS;
    localparam int RST_ROWS = (DEF_ROWS > MAX_ROWS) ? MAX_ROWS : DEF_ROWS;

    logic [CNW-1:0]    cols_reg, cols_next, cols_new;
    logic [RNW-1:0]    rows_reg, rows_next, rows_new;
    logic [TW-1:0]     total_reg, total_next;
    logic [TW-1:0]     copy_reg, copy_next;
    logic [ATTR_W-1:0] text_reg, text_next;
    logic [ATTR_W-1:0] blank_reg, blank_next;
    logic [ROWS_CFG_W-1:0] rows_data;

    assign cfg_ready = 1'b1;
    assign rows_data = cfg_data[ROWS_CFG_W-1:0];

    // clamp to 1..MAX
    always_comb
    begin
        if (cfg_data == '0)
            cols_new = CNW'(1);
        else if (16'(cfg_data) > 16'(MAX_COLUMNS))
            cols_new = CNW'(MAX_COLUMNS);
        else
            cols_new = CNW'(cfg_data);

        if (rows_data == '0)
            rows_new = RNW'(1);
        else if (16'(rows_data) > 16'(MAX_ROWS))
            rows_new = RNW'(MAX_ROWS);
        else
            rows_new = RNW'(rows_data);
    end

    always_comb
    begin
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        text_next  = text_reg;
        blank_next = blank_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLUMNS:    cols_next  = cols_new;
                CFG_ROWS:       rows_next  = rows_new;
                CFG_TEXT_ATTR:  text_next  = cfg_data;
                CFG_BLANK_ATTR: blank_next = cfg_data;
                default:        text_next  = text_reg;
            endcase
        end
        total_next = TW'(cols_next) * TW'(rows_next);
        copy_next  = TW'(cols_next) * TW'(rows_next - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= CNW'(RST_COLS);
            rows_reg  <= RNW'(RST_ROWS);
            total_reg <= TW'(RST_COLS * RST_ROWS);
            copy_reg  <= TW'(RST_COLS * (RST_ROWS - 1));
            text_reg  <= DEF_TEXT_ATTR;
            blank_reg <= DEF_BLANK_ATTR;
        end
        else
        begin
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
            total_reg <= total_next;
            copy_reg  <= copy_next;
            text_reg  <= text_next;
            blank_reg <= blank_next;
        end
    end

    assign cols       = cols_reg;
    assign rows       = rows_reg;
    assign total      = total_reg;
    assign copy_lim   = copy_reg;
    assign text_attr  = text_reg;
    assign blank_attr = blank_reg;

endmodule

// ----- sv/tcw_screen_mem.sv -----
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem
    import tcw_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLUMNS * DEF_MAX_ROWS,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] cells_mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            cells_mem[waddr] <= wdata;
        if (re)
            rdata_reg <= cells_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Operation sequencer: cursor state, address multiplier, cell writes,
// screen sweeps (power-up fill, clear, scroll) and the result register.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int TAB_STOP    = DEF_TAB_STOP,
    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS,
    localparam int CW         = $clog2(MAX_COLUMNS),
    localparam int RW         = $clog2(MAX_ROWS),
    localparam int CNW        = $clog2(MAX_COLUMNS + 1),
    localparam int RNW        = $clog2(MAX_ROWS + 1),
    localparam int AW         = $clog2(CELL_COUNT),
    localparam int TW         = $clog2(CELL_COUNT + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   operation,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [TCOL_W-1:0] target_col,
    input  logic [TROW_W-1:0] target_row,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TCOL_W-1:0] cursor_col,
    output logic [TROW_W-1:0] cursor_row,
    output logic [POS_W-1:0]  cursor_position,
    output logic [CHAR_W-1:0] cell_char,
    output logic [ATTR_W-1:0] cell_attr,
    input  logic [CNW-1:0]    cols,
    input  logic [RNW-1:0]    rows,
    input  logic [TW-1:0]     total,
    input  logic [TW-1:0]     copy_lim,
    input  logic [ATTR_W-1:0] text_attr,
    input  logic [ATTR_W-1:0] blank_attr,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [CELL_W-1:0] mem_wdata,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    input  logic [CELL_W-1:0] mem_rdata
);

    localparam int NW = $clog2(TAB_STOP + 1);
    localparam int MW = RW + CNW + 1;

    localparam logic [3:0] S_SWEEP   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_EXEC    = 4'd2;
    localparam logic [3:0] S_RD_ADDR = 4'd3;
    localparam logic [3:0] S_RD_MEM  = 4'd4;
    localparam logic [3:0] S_RD_DATA = 4'd5;
    localparam logic [3:0] S_PR_ADDR = 4'd6;
    localparam logic [3:0] S_PR_WR   = 4'd7;
    localparam logic [3:0] S_SETTLE  = 4'd8;
    localparam logic [3:0] S_POS     = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    localparam logic [1:0] K_INIT   = 2'd0;
    localparam logic [1:0] K_CLEAR  = 2'd1;
    localparam logic [1:0] K_SCROLL = 2'd2;

    // spaces to the next tab stop, by column
    typedef logic [NW-1:0] tab_lut_t [MAX_COLUMNS];

    function automatic tab_lut_t build_tab_lut();
        tab_lut_t lut;
        int       phase;
        phase = 0;
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            lut[i] = NW'(TAB_STOP - phase);
            phase  = (phase == TAB_STOP - 1) ? 0 : phase + 1;
        end
        return lut;
    endfunction

    localparam tab_lut_t TAB_LUT = build_tab_lut();

    // control state
    logic [3:0]        state_reg, state_next;
    logic [1:0]        kind_reg, kind_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [OP_W-1:0]   op_reg, op_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [CW-1:0]     tc_reg, tc_next;
    logic [RW-1:0]     tr_reg, tr_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic              wr_copy_reg, wr_copy_next;
    logic [CELL_W-1:0] wr_word_reg, wr_word_next;
    logic [TCOL_W-1:0] out_col_reg, out_col_next;
    logic [TROW_W-1:0] out_row_reg, out_row_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [CELL_W-1:0] out_cell_reg, out_cell_next;

    logic [RW-1:0]     mul_row;
    logic [CW-1:0]     mul_col;
    logic [MW-1:0]     mul_full;
    logic [AW-1:0]     mul_addr;
    logic [TW-1:0]     sweep_end;
    logic              sweep_copy;
    logic              col_last;
    logic              row_last;

    // row * columns + col, shared by the read, print and position address computations
    assign mul_full = MW'(mul_row) * MW'(cols) + MW'(mul_col);
    assign mul_addr = AW'(mul_full);

    assign sweep_end  = (kind_reg == K_INIT) ? TW'(CELL_COUNT - 1) : total - 1'b1;
    assign sweep_copy = (kind_reg == K_SCROLL) && (TW'(idx_reg) < copy_lim);
    assign col_last   = (CNW'(col_reg) == cols - 1'b1);
    assign row_last   = (RNW'(row_reg) == rows - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        wr_pend_next   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        op_next        = op_reg;
        ch_next        = ch_reg;
        tc_next        = tc_reg;
        tr_next        = tr_reg;
        cell_next      = cell_reg;
        addr_next      = addr_reg;
        wr_addr_next   = wr_addr_reg;
        wr_copy_next   = 1'b0;
        wr_word_next   = wr_word_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_pos_next   = out_pos_reg;
        out_cell_next  = out_cell_reg;
        mul_row        = row_reg;
        mul_col        = col_reg;
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                // read one row ahead for scroll, write in the following cycle
                mem_re       = sweep_copy;
                mem_raddr    = AW'(TW'(idx_reg) + TW'(cols));
                wr_pend_next = 1'b1;
                wr_addr_next = idx_reg;
                wr_copy_next = sweep_copy;
                wr_word_next = (kind_reg == K_INIT) ? RESET_CELL
                                                    : {blank_attr, {CHAR_W{1'b0}}};
                if (TW'(idx_reg) == sweep_end)
                begin
                    idx_next = '0;
                    priority if (kind_reg == K_INIT)
                        state_next = S_IDLE;
                    else if (cnt_reg != '0)
                        state_next = S_PR_ADDR;
                    else
                        state_next = S_POS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = operation;
                    ch_next   = char_code;
                    cnt_next  = '0;
                    cell_next = '0;
                    tc_next   = (16'(target_col) >= 16'(cols)) ? CW'(cols - 1'b1)
                                                               : CW'(target_col);
                    tr_next   = (16'(target_row) >= 16'(rows)) ? RW'(rows - 1'b1)
                                                               : RW'(target_row);
                    if (16'(col_reg) >= 16'(cols))
                        col_next = CW'(cols - 1'b1);
                    if (16'(row_reg) >= 16'(rows))
                        row_next = RW'(rows - 1'b1);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (op_reg)
                    OP_PUT:
                    begin
                        priority if (ch_reg == CH_NL)
                        begin
                            col_next = '0;
                            if (row_last)
                            begin
                                kind_next  = K_SCROLL;
                                idx_next   = '0;
                                state_next = S_SWEEP;
                            end
                            else
                            begin
                                row_next   = row_reg + 1'b1;
                                state_next = S_POS;
                            end
                        end
                        else if (ch_reg == CH_CR)
                        begin
                            col_next   = '0;
                            state_next = S_POS;
                        end
                        else if (ch_reg == CH_TAB)
                        begin
                            cnt_next   = TAB_LUT[col_reg];
                            ch_next    = CH_SPACE;
                            state_next = S_PR_ADDR;
                        end
                        else
                        begin
                            cnt_next   = NW'(1);
                            state_next = S_PR_ADDR;
                        end
                    end
                    OP_SET:
                    begin
                        col_next   = tc_reg;
                        row_next   = tr_reg;
                        state_next = S_POS;
                    end
                    OP_READ:
                    begin
                        state_next = S_RD_ADDR;
                    end
                    OP_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        kind_next  = K_CLEAR;
                        idx_next   = '0;
                        state_next = S_SWEEP;
                    end
                    default:
                    begin
                        state_next = S_POS;
                    end
                endcase
            end

            S_RD_ADDR:
            begin
                mul_row    = tr_reg;
                mul_col    = tc_reg;
                addr_next  = mul_addr;
                state_next = S_RD_MEM;
            end

            S_RD_MEM:
            begin
                mem_re     = 1'b1;
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                cell_next  = mem_rdata;
                state_next = S_POS;
            end

            S_PR_ADDR:
            begin
                addr_next  = mul_addr;
                state_next = S_PR_WR;
            end

            S_PR_WR:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = addr_reg;
                wr_word_next = {text_attr, ch_reg};
                cnt_next     = cnt_reg - 1'b1;
                state_next   = (cnt_reg == NW'(1)) ? S_POS : S_PR_ADDR;
                if (col_last)
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        // let the print write land before the scroll reads
                        kind_next  = K_SCROLL;
                        idx_next   = '0;
                        state_next = S_SETTLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end

            S_SETTLE:
            begin
                state_next = S_SWEEP;
            end

            S_POS:
            begin
                addr_next  = mul_addr;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = TCOL_W'(col_reg);
                    out_row_next   = TROW_W'(row_reg);
                    out_pos_next   = POS_W'(addr_reg);
                    out_cell_next  = cell_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            kind_reg      <= K_INIT;
            idx_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        tc_reg       <= tc_next;
        tr_reg       <= tr_next;
        cell_reg     <= cell_next;
        addr_reg     <= addr_next;
        wr_addr_reg  <= wr_addr_next;
        wr_copy_reg  <= wr_copy_next;
        wr_word_reg  <= wr_word_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_pos_reg  <= out_pos_next;
        out_cell_reg <= out_cell_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    assign mem_we    = wr_pend_reg;
    assign mem_waddr = wr_addr_reg;
    assign mem_wdata = wr_copy_reg ? mem_rdata : wr_word_reg;

    assign out_valid       = out_valid_reg;
    assign cursor_col      = out_col_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_position = out_pos_reg;
    assign cell_char       = out_cell_reg[CHAR_W-1:0];
    assign cell_attr       = out_cell_reg[CELL_W-1:CHAR_W];

endmodule

// ----- sv/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with a cursor, wrap, tab stops and scrolling.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : register writes (columns, rows, text and blank attribute), taken
//            every cycle; write only while no word is in flight.
//   in_*   : one operation word (put char, set cursor, read cell, clear).
//   out_*  : one result word per operation: cursor column/row/position and,
//            for a read, the cell's character and attribute (zero otherwise).
// Steps: a print passes an address state and a write state per character
//   or tab space. A scroll sweeps rows*columns cells, one cell moved per
//   cycle through the single write port, after a settle state when a print
//   wraps into it; clear sweeps the rows*columns cells in use.
// The block returns to idle, ready for a new word, as the result is registered.
// Reset: cursor to 0,0, registers to defaults, then a fill pass writes the
//   power-up cell to all MAX_COLUMNS*MAX_ROWS entries with in_ready low;
//   register writes are still taken.
// Stall: a held result does not stop the next word from being accepted;
//   its result waits in the final state until out_ready frees the register.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int TAB_STOP    = DEF_TAB_STOP
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       operation,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [TCOL_W-1:0]     target_col,
    input  logic [TROW_W-1:0]     target_row,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TCOL_W-1:0]     cursor_col,
    output logic [TROW_W-1:0]     cursor_row,
    output logic [POS_W-1:0]      cursor_position,
    output logic [CHAR_W-1:0]     cell_char,
    output logic [ATTR_W-1:0]     cell_attr
);

    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int CNW        = $clog2(MAX_COLUMNS + 1);
    localparam int RNW        = $clog2(MAX_ROWS + 1);
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int TW         = $clog2(CELL_COUNT + 1);

    // effective (clamped) geometry and attributes
    logic [CNW-1:0]    cols;
    logic [RNW-1:0]    rows;
    logic [TW-1:0]     total;
    logic [TW-1:0]     copy_lim;
    logic [ATTR_W-1:0] text_attr;
    logic [ATTR_W-1:0] blank_attr;

    // cell store ports
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    tcw_cfg_regs #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cols       (cols),
        .rows       (rows),
        .total      (total),
        .copy_lim   (copy_lim),
        .text_attr  (text_attr),
        .blank_attr (blank_attr)
    );

    tcw_screen_mem #(
        .DEPTH (CELL_COUNT)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcw_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAB_STOP    (TAB_STOP)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .char_code       (char_code),
        .target_col      (target_col),
        .target_row      (target_row),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attr       (cell_attr),
        .cols            (cols),
        .rows            (rows),
        .total           (total),
        .copy_lim        (copy_lim),
        .text_attr       (text_attr),
        .blank_attr      (blank_attr),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

`ifndef SYNTHESIS
    // one word in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an operation is in work");

    // scroll read-ahead and pending writes never hit the same cell
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re && mem_we |-> mem_raddr != mem_waddr)
        else $error("cell store read and write at the same address");

    // reported cursor lies inside the screen in use
    a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (16'(cursor_col) < 16'(cols)) && (16'(cursor_row) < 16'(rows)))
        else $error("cursor outside the screen");
`endif

endmodule

// ----- bench/text_console_writer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console. A short directed list runs at
// the reset geometry first: reads of blank cells, wrap, tab, newline and
// return, scroll on the last row, clamped targets and clear. Random words
// follow over a series of screen geometries, including out-of-range register
// values. A shadow console tracks the cell store and the cursor, and each
// result word is checked against it in order.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_COLS       = DEF_MAX_COLUMNS;
    localparam int MAX_LINES      = DEF_MAX_ROWS;
    localparam int TAB_WIDTH      = DEF_TAB_STOP;
    localparam int CELLS          = MAX_COLS * MAX_LINES;
    // Longest quiet stretch: power-up fill or a full-screen scroll or clear
    // plus receiver stalls, taken several times over.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DIRECTED_WORDS = 25;
    localparam int PHASES         = 11;

    // One operation word as it goes into the block
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [TCOL_W-1:0] col;
        logic [TROW_W-1:0] row;
    } console_cmd_t;

    // One result word: cursor after the operation and the cell read
    typedef struct packed {
        logic [TCOL_W-1:0] col;
        logic [TROW_W-1:0] row;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
    } console_view_t;

    // Directed entry; 'typed' marks a result written in by hand
    typedef struct packed {
        console_cmd_t  cmd;
        logic          typed;
        console_view_t view;
    } directed_word_t;

    // Screen setting and traffic shape for one random stretch
    typedef struct packed {
        logic [7:0]  cols;
        logic [7:0]  rows;
        logic [7:0]  text;
        logic [7:0]  blank;
        logic [7:0]  send_gap;
        logic [7:0]  recv_gap;
        logic [15:0] words;
    } screen_phase_t;

    // ------------------------------------------------------------------
    // DUT signals; the inputs are all known from time zero
    // ------------------------------------------------------------------
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       operation  = '0;
    logic [CHAR_W-1:0]     char_code  = '0;
    logic [TCOL_W-1:0]     target_col = '0;
    logic [TROW_W-1:0]     target_row = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [TCOL_W-1:0]     cursor_col;
    logic [TROW_W-1:0]     cursor_row;
    logic [POS_W-1:0]      cursor_position;
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attr;

    text_console_writer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .char_code       (char_code),
        .target_col      (target_col),
        .target_row      (target_row),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attr       (cell_attr)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow console: register copies, cell store and cursor
    // ------------------------------------------------------------------
    logic [7:0]          shadow_columns    = 8'(DEF_COLUMNS);
    logic [5:0]          shadow_rows       = 6'(DEF_ROWS);
    logic [7:0]          shadow_text_attr  = DEF_TEXT_ATTR;
    logic [7:0]          shadow_blank_attr = DEF_BLANK_ATTR;
    logic [CELL_W-1:0]   screen_img [CELLS];
    int unsigned         cur_col = 0;
    int unsigned         cur_row = 0;

    console_view_t       expected_views [$];
    int                  send_gap_pct = 0;
    int                  recv_gap_pct = 0;
    int                  fail_count   = 0;
    int                  words_sent   = 0;
    int                  views_checked = 0;
    int                  reg_writes   = 0;
    int                  scroll_count = 0;
    int                  quiet_cycles = 0;
    console_view_t       seen_view;
    console_view_t       want_view;

    // Registers outside their range are used clamped
    function automatic int unsigned used_cols();
        if (shadow_columns == 0) return 1;
        if (shadow_columns > MAX_COLS) return MAX_COLS;
        return shadow_columns;
    endfunction

    function automatic int unsigned used_rows();
        if (shadow_rows == 0) return 1;
        if (shadow_rows > MAX_LINES) return MAX_LINES;
        return shadow_rows;
    endfunction

    function automatic int unsigned cell_addr(int unsigned c, int unsigned r);
        return (r * used_cols() + c) % CELLS;
    endfunction

    // Wrap past the last column, scroll past the last row
    function automatic void settle_cursor();
        int unsigned c;
        int unsigned r;
        int unsigned x;
        int unsigned y;
        c = used_cols();
        r = used_rows();
        if (cur_col >= c)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= r)
        begin
            for (y = 1; y < r; y++)
                for (x = 0; x < c; x++)
                    screen_img[cell_addr(x, y - 1)] = screen_img[cell_addr(x, y)];
            for (x = 0; x < c; x++)
                screen_img[cell_addr(x, r - 1)] = {shadow_blank_attr, 8'h00};
            if (cur_row > 0) cur_row--;
            scroll_count++;
        end
    endfunction

    function automatic void print_char(logic [CHAR_W-1:0] ch);
        screen_img[cell_addr(cur_col, cur_row)] = {shadow_text_attr, ch};
        cur_col++;
        settle_cursor();
    endfunction

    // Applies one word to the shadow console and returns its result word
    function automatic console_view_t next_console_view(console_cmd_t cmd);
        console_view_t view;
        int unsigned   c;
        int unsigned   r;
        int unsigned   tc;
        int unsigned   tr;
        int unsigned   x;
        int unsigned   y;
        int unsigned   linear;
        logic [CELL_W-1:0] cell_word;
        view = '0;
        c    = used_cols();
        r    = used_rows();
        tc   = cmd.col;
        tr   = cmd.row;
        // a shrunk screen pulls the cursor and the target inside it
        if (cur_col >= c) cur_col = c - 1;
        if (cur_row >= r) cur_row = r - 1;
        if (tc >= c) tc = c - 1;
        if (tr >= r) tr = r - 1;
        case (cmd.op)
            OP_PUT:
            begin
                case (cmd.ch)
                    CH_NL:
                    begin
                        cur_col = 0;
                        cur_row++;
                        settle_cursor();
                    end
                    CH_CR: cur_col = 0;
                    // space count is fixed before the first space goes out
                    CH_TAB:
                        repeat (TAB_WIDTH - (cur_col % TAB_WIDTH))
                            print_char(CH_SPACE);
                    default: print_char(cmd.ch);
                endcase
            end
            OP_SET:
            begin
                cur_col = tc;
                cur_row = tr;
            end
            OP_READ:
            begin
                cell_word = screen_img[cell_addr(tc, tr)];
                view.ch   = cell_word[CHAR_W-1:0];
                view.attr = cell_word[CELL_W-1:CHAR_W];
            end
            OP_CLEAR:
            begin
                // only the cells in use are blanked
                for (y = 0; y < r; y++)
                    for (x = 0; x < c; x++)
                        screen_img[cell_addr(x, y)] = {shadow_blank_attr, 8'h00};
                cur_col = 0;
                cur_row = 0;
            end
        endcase
        linear    = cur_row * used_cols() + cur_col;
        view.col  = cur_col[TCOL_W-1:0];
        view.row  = cur_row[TROW_W-1:0];
        view.pos  = linear[POS_W-1:0];
        return view;
    endfunction

    // Random word: mostly printing, targets mostly on screen, some beyond
    function automatic console_cmd_t random_cmd();
        console_cmd_t cmd;
        int unsigned  pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)      cmd.op = OP_PUT;
        else if (pick < 75) cmd.op = OP_SET;
        else if (pick < 96) cmd.op = OP_READ;
        else                cmd.op = OP_CLEAR;
        pick = $urandom_range(0, 99);
        if (pick < 15)      cmd.ch = CH_NL;
        else if (pick < 23) cmd.ch = CH_CR;
        else if (pick < 38) cmd.ch = CH_TAB;
        else if (pick < 85) cmd.ch = CHAR_W'($urandom_range(32, 126));
        else                cmd.ch = CHAR_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
        begin
            cmd.col = TCOL_W'($urandom_range(0, 127));
            cmd.row = TROW_W'($urandom_range(0, 31));
        end
        else
        begin
            cmd.col = TCOL_W'($urandom_range(0, used_cols() - 1));
            cmd.row = TROW_W'($urandom_range(0, used_rows() - 1));
        end
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // Directed words at the reset geometry (80 x 25, text 0F, blank 07)
    // ------------------------------------------------------------------
    directed_word_t directed_words [DIRECTED_WORDS] = '{
        // blank cell after power-up, then a target far off screen
        '{'{OP_READ, 8'h00, 7'd0, 5'd0},    1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h07}},
        '{'{OP_READ, 8'h00, 7'd127, 5'd31}, 1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h07}},
        '{'{OP_PUT, 8'h41, 7'd0, 5'd0},     1'b1, '{7'd1, 5'd0, 12'd1, 8'h00, 8'h00}},
        '{'{OP_READ, 8'h00, 7'd0, 5'd0},    1'b1, '{7'd1, 5'd0, 12'd1, 8'h41, 8'h0F}},
        // tab from column 1 writes three spaces
        '{'{OP_PUT, CH_TAB, 7'd0, 5'd0},    1'b1, '{7'd4, 5'd0, 12'd4, 8'h00, 8'h00}},
        '{'{OP_READ, 8'h00, 7'd3, 5'd0},    1'b1, '{7'd4, 5'd0, 12'd4, CH_SPACE, 8'h0F}},
        '{'{OP_PUT, CH_CR, 7'd0, 5'd0},     1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h00}},
        '{'{OP_PUT, CH_NL, 7'd0, 5'd0},     1'b1, '{7'd0, 5'd1, 12'd80, 8'h00, 8'h00}},
        // bottom-right corner, then print there: wrap and scroll
        '{'{OP_SET, 8'h00, 7'd127, 5'd31},  1'b1, '{7'd79, 5'd24, 12'd1999, 8'h00, 8'h00}},
        '{'{OP_PUT, 8'hFF, 7'd0, 5'd0},     1'b1, '{7'd0, 5'd24, 12'd1920, 8'h00, 8'h00}},
        '{'{OP_READ, 8'h00, 7'd79, 5'd23},  1'b1, '{7'd0, 5'd24, 12'd1920, 8'hFF, 8'h0F}},
        '{'{OP_READ, 8'h00, 7'd79, 5'd24},  1'b1, '{7'd0, 5'd24, 12'd1920, 8'h00, 8'h07}},
        '{'{OP_PUT, 8'h00, 7'd0, 5'd0},     1'b0, '0},
        // tab that wraps off the last column on the last row
        '{'{OP_SET, 8'h00, 7'd77, 5'd24},   1'b1, '{7'd77, 5'd24, 12'd1997, 8'h00, 8'h00}},
        '{'{OP_PUT, CH_TAB, 7'd0, 5'd0},    1'b0, '0},
        '{'{OP_PUT, CH_NL, 7'd0, 5'd0},     1'b0, '0},
        '{'{OP_SET, 8'h00, 7'd0, 5'd0},     1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h00}},
        '{'{OP_PUT, CH_TAB, 7'd0, 5'd0},    1'b0, '0},
        '{'{OP_PUT, 8'h7F, 7'd0, 5'd0},     1'b0, '0},
        '{'{OP_PUT, 8'h80, 7'd0, 5'd0},     1'b0, '0},
        '{'{OP_READ, 8'h00, 7'd0, 5'd22},   1'b0, '0},
        // clear, then the blank cell it leaves
        '{'{OP_CLEAR, 8'h00, 7'd0, 5'd0},   1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h00}},
        '{'{OP_READ, 8'h00, 7'd0, 5'd24},   1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h07}},
        '{'{OP_SET, 8'h00, 7'd5, 5'd3},     1'b1, '{7'd5, 5'd3, 12'd245, 8'h00, 8'h00}},
        '{'{OP_PUT, CH_CR, 7'd0, 5'd0},     1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Random stretches. Register values past the legal range are in on
    // purpose: columns 0 / 255, rows 0 and 63 (and 0x40, which the 6-bit
    // register sees as 0). Only one stretch uses the full 128 x 32 screen
    // since every scroll there costs a pass over 4096 cells.
    // ------------------------------------------------------------------
    screen_phase_t screen_phases [PHASES] = '{
        '{8'd8,   8'd4,   8'h1E, 8'h70, 8'd30, 8'd63, 16'd140},
        '{8'd1,   8'd1,   8'h00, 8'hFF, 8'd30, 8'd63, 16'd100},
        '{8'd0,   8'd0,   8'h5A, 8'hA5, 8'd30, 8'd63, 16'd60},
        '{8'd255, 8'd2,   8'hFF, 8'h00, 8'd30, 8'd63, 16'd100},
        '{8'd5,   8'd3,   8'hC3, 8'h3C, 8'd63, 8'd30, 16'd130},
        '{8'd16,  8'd8,   8'h81, 8'h18, 8'd63, 8'd30, 16'd140},
        '{8'd128, 8'd32,  8'hFF, 8'h00, 8'd63, 8'd30, 16'd30},
        '{8'd3,   8'hFF,  8'h42, 8'h24, 8'd63, 8'd30, 16'd130},
        '{8'd12,  8'h40,  8'h0F, 8'h07, 8'd0,  8'd0,  16'd100},
        '{8'd7,   8'd5,   8'h66, 8'h99, 8'd0,  8'd0,  16'd190},
        '{8'd80,  8'd25,  8'h0F, 8'h07, 8'd0,  8'd0,  16'd40}
    };

    // Sends one word, with random gaps ahead of it, and records what it
    // should produce once the block takes it
    task automatic issue_word(input console_cmd_t cmd, input logic typed,
                              input console_view_t typed_view);
        console_view_t model_view;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= cmd.op;
        char_code  <= cmd.ch;
        target_col <= cmd.col;
        target_row <= cmd.row;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // the shadow console advances even when the result is typed in
        model_view = next_console_view(cmd);
        expected_views.push_back(typed ? typed_view : model_view);
        words_sent++;
    endtask

    // One register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_COLUMNS:    shadow_columns    = val;
            CFG_ROWS:       shadow_rows       = val[ROWS_CFG_W-1:0];
            CFG_TEXT_ATTR:  shadow_text_attr  = val;
            CFG_BLANK_ATTR: shadow_blank_attr = val;
        endcase
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stalls. Outputs are sampled at the
    // rising edge, before this edge's updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_view = {cursor_col, cursor_row, cursor_position, cell_char, cell_attr};
            if (expected_views.size() == 0)
            begin
                if (fail_count < 10)
                    $display({"%0t: result word with nothing outstanding: ",
                              "col %0d row %0d pos %0d char %02h attr %02h"},
                             $time, seen_view.col, seen_view.row, seen_view.pos,
                             seen_view.ch, seen_view.attr);
                fail_count++;
            end
            else
            begin
                want_view = expected_views.pop_front();
                if (want_view.col !== seen_view.col || want_view.row !== seen_view.row ||
                    want_view.pos !== seen_view.pos || want_view.ch !== seen_view.ch ||
                    want_view.attr !== seen_view.attr)
                begin
                    if (fail_count < 10)
                        $display({"%0t: mismatch on result %0d: ",
                                  "want col %0d row %0d pos %0d char %02h attr %02h, ",
                                  "got col %0d row %0d pos %0d char %02h attr %02h"},
                                 $time, views_checked,
                                 want_view.col, want_view.row, want_view.pos,
                                 want_view.ch, want_view.attr,
                                 seen_view.col, seen_view.row, seen_view.pos,
                                 seen_view.ch, seen_view.attr);
                    fail_count++;
                end
            end
            views_checked++;
        end
        out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    // Watchdog: cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_views.size());
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int           i;
        int           p;
        console_cmd_t cmd;

        for (i = 0; i < CELLS; i++) screen_img[i] = RESET_CELL;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed list: sender lazy, receiver lazier
        send_gap_pct = 30;
        recv_gap_pct = 63;
        for (i = 0; i < DIRECTED_WORDS; i++)
            issue_word(directed_words[i].cmd, directed_words[i].typed,
                       directed_words[i].view);

        for (p = 0; p < PHASES; p++)
        begin
            in_valid <= 1'b0;
            // sender holds off until every result is back; the block is
            // then idle and the screen setting may change
            while (expected_views.size() != 0) @(posedge clk);
            repeat (8) @(posedge clk);
            write_reg(CFG_COLUMNS,    screen_phases[p].cols);
            write_reg(CFG_ROWS,       screen_phases[p].rows);
            write_reg(CFG_TEXT_ATTR,  screen_phases[p].text);
            write_reg(CFG_BLANK_ATTR, screen_phases[p].blank);
            cfg_valid <= 1'b0;

            send_gap_pct = screen_phases[p].send_gap;
            recv_gap_pct = screen_phases[p].recv_gap;
            for (i = 0; i < screen_phases[p].words; i++)
            begin
                cmd = random_cmd();
                issue_word(cmd, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        // drain, then a short tail to catch stray result words
        while (expected_views.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Summary: %0d operation words over %0d screen settings, %0d results checked",
                 words_sent, PHASES + 1, views_checked);
        $display("Summary: %0d register writes, %0d scrolls in the shadow console, %0d mismatches",
                 reg_writes, scroll_count, fail_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
